// ===== src/sha_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 digest block.
`timescale 1ns / 1ps
package sha_pkg;

	localparam int BLOCK_W         = 512;
	localparam int BLOCK_BYTES     = 64;
	localparam int WORD_W          = 32;
	localparam int ROUNDS          = 64;
	localparam int QUEUE_DEPTH_DEF = 2;

	typedef logic [WORD_W-1:0] word_t;

	// One block handed from the byte packer to the compression core.
	typedef struct packed {
		logic               last_blk;
		logic [BLOCK_W-1:0] data;
	} blk_t;

	localparam word_t ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam word_t INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic word_t big_sigma0(input word_t x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic word_t small_sigma0(input word_t x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic word_t small_sigma1(input word_t x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// ===== src/sha_fifo.sv =====
// Small register queue of blocks between the byte packer and the core.
`timescale 1ns / 1ps
module sha_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/sha_front.sv =====
// Byte packer: gathers bytes into blocks, pads on finish, tracks bit length.
`timescale 1ns / 1ps
module sha_front
	import sha_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [7:0] data_byte,
	output logic       push,
	output blk_t       push_blk,
	input  logic       full
);

	logic [7:0]  buf_q [BLOCK_BYTES];
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic        pend_q;

	logic        acc;
	logic [63:0] total;
	logic [7:0]  pad_b  [BLOCK_BYTES];
	logic [7:0]  full_b [BLOCK_BYTES];
	logic [7:0]  tail_b [BLOCK_BYTES];
	logic [BLOCK_W-1:0] pad_v, full_v, tail_v;

	assign in_ready = !full && !pend_q;
	assign acc      = in_valid && in_ready;
	assign total    = len_q + {55'b0, fill_q, 3'b000};

	always_comb begin
		for (int i = 0; i < BLOCK_BYTES; i++) begin
			full_b[i] = (6'(i) == fill_q) ? data_byte : buf_q[i];
			if (6'(i) < fill_q) begin
				pad_b[i] = buf_q[i];
			end else if (6'(i) == fill_q) begin
				pad_b[i] = 8'h80;
			end else begin
				pad_b[i] = 8'h00;
			end
			tail_b[i] = 8'h00;
		end
		// length goes in the last eight bytes, big-endian
		for (int i = 0; i < 8; i++) begin
			tail_b[56 + i] = len_q[63 - 8*i -: 8];
			if (fill_q < 6'd56) begin
				pad_b[56 + i] = total[63 - 8*i -: 8];
			end
		end
		for (int i = 0; i < BLOCK_BYTES; i++) begin
			pad_v[BLOCK_W - 1 - 8*i -: 8]  = pad_b[i];
			full_v[BLOCK_W - 1 - 8*i -: 8] = full_b[i];
			tail_v[BLOCK_W - 1 - 8*i -: 8] = tail_b[i];
		end
	end

	always_comb begin
		push     = 1'b0;
		push_blk = '{last_blk: 1'b0, data: full_v};
		if (pend_q) begin
			push     = !full;
			push_blk = '{last_blk: 1'b1, data: tail_v};
		end else if (acc && action) begin
			push     = 1'b1;
			push_blk = '{last_blk: (fill_q < 6'd56), data: pad_v};
		end else if (acc && (fill_q == 6'd63)) begin
			push = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !action) begin
			buf_q[fill_q] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			pend_q <= 1'b0;
		end else if (pend_q) begin
			if (!full) begin
				pend_q <= 1'b0;
				len_q  <= '0;
			end
		end else if (acc) begin
			if (action) begin
				fill_q <= '0;
				// padding spills into a second block: hold total for it
				if (fill_q >= 6'd56) begin
					pend_q <= 1'b1;
					len_q  <= total;
				end else begin
					len_q <= '0;
				end
			end else begin
				fill_q <= fill_q + 1'b1;
				if (fill_q == 6'd63) begin
					len_q <= len_q + 64'd512;
				end
			end
		end
	end

endmodule

// ===== src/sha_core.sv =====
// Compression core: one round per cycle, chaining words, digest output.
`timescale 1ns / 1ps
module sha_core
	import sha_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  blk_t       q_blk,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output word_t      digest_word,
	output logic [2:0] word_index,
	output logic       last_word
);

	typedef enum logic [1:0] {S_IDLE, S_ROUND, S_ADD, S_OUT} state_t;

	state_t     state_q;
	word_t      hash_q [8];
	word_t      v_q    [8];
	word_t      w_q    [16];
	logic [5:0] rnd_q;
	logic       last_q;
	logic [2:0] idx_q;
	logic       out_valid_q;

	word_t t1, t2, w_new;

	assign pop         = (state_q == S_IDLE) && q_valid;
	assign out_valid   = out_valid_q;
	assign digest_word = hash_q[idx_q];
	assign word_index  = idx_q;
	assign last_word   = (idx_q == 3'd7);

	always_comb begin
		t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ ROUND_K[rnd_q] + w_q[0];
		t2 = big_sigma0(v_q[0])
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
	end

	// working variables and message schedule window
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= q_blk.data[BLOCK_W - 1 - WORD_W*i -: WORD_W];
			end
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= hash_q[i];
			end
		end else if (state_q == S_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rnd_q       <= '0;
			last_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= INIT_HASH[i];
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_ROUND;
						rnd_q   <= '0;
						last_q  <= q_blk.last_blk;
					end
				end
				S_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 6'(ROUNDS - 1)) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + v_q[i];
					end
					if (last_q) begin
						state_q     <= S_OUT;
						idx_q       <= '0;
						out_valid_q <= 1'b1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						if (idx_q == 3'd7) begin
							out_valid_q <= 1'b0;
							state_q     <= S_IDLE;
							for (int i = 0; i < 8; i++) begin
								hash_q[i] <= INIT_HASH[i];
							end
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/sha256_message_digest.sv =====
// Top level of the SHA-256 digest block: packer, block queue and core.
`timescale 1ns / 1ps
// Digest word 0 shows once the last block of a message has left the queue and passed the rounds
//   and the chaining add; if padding spills into a second block, both padded blocks pass them.
// Throughput: one byte per cycle while in_ready is high; once the block queue fills, the core
//   sets the rate, taking a new 64-byte block only after load, 64 rounds and chaining add.
// Digest words leave one per cycle while out_ready is high; no block loads until all have left.
// Reset (arst_n low, asynchronous): empty queue, zero length, initial hash values.
module sha256_message_digest
	import sha_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	// blocks travel from the packer to the core through this queue
	blk_t push_blk, pop_blk;
	logic push, full, pop, empty;

	// packer: absorb bytes, pad on finish, push whole blocks
	sha_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.data_byte (data_byte),
		.push      (push),
		.push_blk  (push_blk),
		.full      (full)
	);

	// decouple the packer from the slow core so each side stalls on its own
	sha_fifo #(
		.WIDTH ($bits(blk_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_blk),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_blk),
		.empty     (empty)
	);

	// core: compress each block; after the final one, transfer eight digest words
	sha_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (!empty),
		.q_blk       (pop_blk),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule

// ===== src/sha_checker.sv =====
// Port-level checks on the digest output sequence of the SHA-256 block.
`timescale 1ns / 1ps
module sha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	// a stalled digest word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word) && $stable(word_index))
		else $error("digest word changed while stalled");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 3'd7)))
		else $error("last_word does not match word_index");

	// words leave in order without gaps
	a_next_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=>
			out_valid && (word_index == $past(word_index) + 3'd1))
		else $error("digest word sequence broken");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_word |=> !out_valid)
		else $error("output stays valid after the last digest word");

endmodule

bind sha256_message_digest sha_checker u_sha_checker (.*);

// ===== bench/sha256_digest_checker.sv =====
// Checker for the SHA-256 digest block: predicts digest words and compares them.
`timescale 1ns / 1ps
module sha256_digest_checker
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        action,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] digest_word,
	input  logic [2:0]  word_index,
	input  logic        last_word,
	output int          fail_count,
	output int          words_pending
);

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_item_t;

	localparam logic ACT_ABSORB = 1'b0;

	logic [7:0]  msg_block [64];
	int          msg_fill;
	logic [63:0] msg_bits;
	word_t       chain [8];
	digest_item_t digest_fifo [$];

	assign words_pending = digest_fifo.size();

	function automatic word_t rotr(input word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_msg_block();
		word_t w [64];
		word_t v [8];
		word_t t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		v = chain;
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] += v[i];
	endtask

	task automatic predict_transfer(input logic act, input logic [7:0] b);
		logic [63:0] total;
		if (act == ACT_ABSORB) begin
			msg_block[msg_fill] = b;
			msg_fill++;
			if (msg_fill == 64) begin
				compress_msg_block();
				msg_bits += 64'd512;
				msg_fill = 0;
			end
		end else begin
			total = msg_bits + 64'(msg_fill * 8);
			msg_block[msg_fill] = 8'h80;
			for (int i = msg_fill + 1; i < 64; i++)
				msg_block[i] = 8'h00;
			if (msg_fill >= 56) begin
				compress_msg_block();
				for (int i = 0; i < 56; i++)
					msg_block[i] = 8'h00;
			end
			for (int i = 0; i < 8; i++)
				msg_block[56+i] = total[63-8*i -: 8];
			compress_msg_block();
			for (int i = 0; i < 8; i++)
				digest_fifo.push_back('{chain[i], 3'(i), i == 7});
			msg_fill = 0;
			msg_bits = '0;
			chain = INIT_HASH;
		end
	endtask

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $realtime, what);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		msg_fill = 0;
		msg_bits = '0;
		chain = INIT_HASH;
	end

	always @(posedge clk) begin
		digest_item_t exp_w;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (digest_fifo.size() == 0)
					report_mismatch("digest word with none expected");
				else begin
					exp_w = digest_fifo.pop_front();
					if (digest_word !== exp_w.word)
						report_mismatch($sformatf("word %0d: got %h expected %h",
							exp_w.index, digest_word, exp_w.word));
					if (word_index !== exp_w.index)
						report_mismatch($sformatf("word_index got %0d expected %0d",
							word_index, exp_w.index));
					if (last_word !== exp_w.last)
						report_mismatch($sformatf("last_word got %b expected %b",
							last_word, exp_w.last));
				end
			end
			if (in_valid && in_ready)
				predict_transfer(action, data_byte);
		end
	end

endmodule

// ===== bench/tb_sha256_message_digest.sv =====
// Testbench top for the SHA-256 digest block: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_sha256_message_digest;
	import sha_pkg::*;

	localparam logic ACT_ABSORB = 1'b0;
	localparam logic ACT_FINISH = 1'b1;
	localparam int   CYCLE_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        action = ACT_ABSORB;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	int          fail_count;
	int          words_pending;
	int          cycle_count = 0;
	bit          hold_off = 1'b0;

	// Clock: 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	sha256_message_digest DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	sha256_digest_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .data_byte(data_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word),
		.fail_count(fail_count), .words_pending(words_pending)
	);

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_sha256_message_digest failed");
			$finish;
		end
	end

	// Receiver stall pattern: runs of ready and stall of random length, with
	// one long hold-off so the block queue fills and in_ready drops.
	initial begin
		int run;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end
			run = $urandom_range(1, 12);
			out_ready <= ($urandom_range(0, 3) != 0);
			repeat (run) @(posedge clk);
		end
	end

	// Present one item and hold it until the transfer happens.
	task automatic send_item(input logic act, input logic [7:0] b);
		in_valid  <= 1'b1;
		action    <= act;
		data_byte <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid for a random gap, unless no gap is wanted.
	task automatic idle_gap(input int max_gap);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Send len bytes, random or all ones, then finish; gaps adds idles.
	task automatic send_message(input int len, input bit fill_ones, input bit gaps);
		int burst;
		burst = $urandom_range(1, 20);
		for (int i = 0; i < len; i++) begin
			send_item(ACT_ABSORB, fill_ones ? 8'hff : 8'($urandom));
			if (gaps && --burst == 0) begin
				idle_gap(6);
				burst = $urandom_range(1, 20);
			end
		end
		send_item(ACT_FINISH, 8'($urandom));
		if (gaps)
			idle_gap(4);
	endtask

	initial begin
		int len;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, extreme bytes, padding edges at 55, 56 and 64.
		send_message(0, 1'b0, 1'b0);
		send_message(1, 1'b1, 1'b0);
		send_item(ACT_ABSORB, 8'h00);
		send_item(ACT_FINISH, 8'hff);
		send_message(3, 1'b0, 1'b1);
		send_message(55, 1'b0, 1'b0);
		send_message(56, 1'b1, 1'b1);
		send_message(64, 1'b0, 1'b0);

		// Long hold-off at the receiver while several short messages keep coming:
		// the core sticks on a digest, the queue fills and the input stalls.
		hold_off = 1'b1;
		send_message(5, 1'b0, 1'b0);
		send_message(5, 1'b0, 1'b0);
		send_message(5, 1'b0, 1'b0);
		send_message(0, 1'b0, 1'b0);

		// Random short messages of 0 to 20 bytes.
		repeat (5) begin
			case ($urandom_range(0, 1))
				0: len = $urandom_range(0, 8);
				default: len = $urandom_range(9, 20);
			endcase
			send_message(len, 1'b0, 1'b1);
		end
		in_valid <= 1'b0;

		// Drain all expected digest words, then allow some settle time.
		@(posedge clk);
		while (words_pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("tb_sha256_message_digest passed");
		else
			$display("tb_sha256_message_digest failed");
		$finish;
	end

endmodule

// ===== sha256_message_digest.f =====
src/sha_pkg.sv
src/sha_fifo.sv
src/sha_front.sv
src/sha_core.sv
src/sha256_message_digest.sv
src/sha_checker.sv
bench/sha256_digest_checker.sv
bench/tb_sha256_message_digest.sv
